[design/dsr_pkg.sv]
// dsr_pkg: shared types, constants and fixed-point helpers for the drive
// setpoint ramp. No dependencies; used by every module under design/.
package dsr_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MAX_SPEED     = 3'd0,
        CFG_SLEW_STEP     = 3'd1,
        CFG_POS_WINDOW    = 3'd2,
        CFG_SPEED_WINDOW  = 3'd3,
        CFG_TICK_PERIOD   = 3'd4
    } t_cfg_idx;

    // Pipeline stage handshake: advance strobe plus valid of the entering word
    typedef struct packed {
        logic adv;
        logic vld;
    } t_stage_ctl;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Register reset values
    localparam logic [19:0] RST_MAX_SPEED    = 20'd163840;
    localparam logic [16:0] RST_SLEW_STEP    = 17'd655;
    localparam logic [16:0] RST_POS_WINDOW   = 17'd6554;
    localparam logic [19:0] RST_SPEED_WINDOW = 20'd98304;
    localparam logic [16:0] RST_TICK_PERIOD  = 17'd328;

    // Division by 660: drop two low bits, then multiply by ceil(2^37/165).
    // Exact for dividends below 2^29.
    localparam logic [29:0] DIV165_MULT  = 30'd832963355;
    localparam int          DIV165_SHIFT = 37;

    // Leg-length step: 0.15 and 0.03 in Q16.16
    localparam logic signed [17:0] LEG_OFFSET = 18'sd9830;
    localparam logic signed [11:0] LEG_GAIN   = 12'sd1966;
    localparam logic signed [17:0] ONE_Q16    = 18'sd65536;
    localparam logic signed [29:0] Q16_ROUND  = 30'sd65535;

    localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SAT_MIN = 36'shF_8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Move cur toward goal by step; snap when strictly closer than step.
    // The result always lies between cur and goal, so it fits 32 bits.
    function automatic logic signed [31:0] slew(input logic signed [31:0] cur,
                                                input logic signed [31:0] goal,
                                                input logic [16:0]        step);
        logic signed [32:0] d;
        logic        [32:0] ad;
        logic signed [32:0] s;
        logic signed [32:0] t;
        logic signed [31:0] r;
        d  = {goal[31], goal} - {cur[31], cur};
        ad = d[32] ? 33'(-d) : 33'(d);
        s  = $signed({16'd0, step});
        if (ad < {16'd0, step}) begin
            r = goal;
        end else begin
            t = (d > 33'sd0) ? ({cur[31], cur} + s) : ({cur[31], cur} - s);
            r = t[31:0];
        end
        return r;
    endfunction

    // Limit v to center +/- win, saturating the window edges
    function automatic logic signed [31:0] clamp_around(input logic signed [31:0] v,
                                                        input logic signed [31:0] c,
                                                        input logic [19:0]        win);
        logic signed [33:0] w;
        logic signed [33:0] diff;
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        logic signed [31:0] r;
        w    = $signed({14'd0, win});
        diff = {{2{v[31]}}, v} - {{2{c[31]}}, c};
        hi   = {{2{c[31]}}, c} + w;
        lo   = {{2{c[31]}}, c} - w;
        if (diff > w) begin
            r = sat32({{2{hi[33]}}, hi});
        end else if (diff < -w) begin
            r = sat32({{2{lo[33]}}, lo});
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[design/dsr_front.sv]
// dsr_front: stateless front stages: stick scaling to desired speed and
// leg-length speed step. Two register stages. Depends on dsr_pkg.
module dsr_front (
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic signed [10:0] i_stick_forward,
    input  logic               i_drive_reversed,
    input  logic [16:0]        i_left_leg_length,
    input  logic [16:0]        i_right_leg_length,
    input  logic signed [31:0] i_measured_position,
    input  logic signed [31:0] i_measured_speed,
    input  logic [19:0]        i_max_speed,
    output logic signed [31:0] o_desired,
    output logic [16:0]        o_step,
    output logic signed [31:0] o_measured_position,
    output logic signed [31:0] o_measured_speed
);

    // stage 1: products
    logic signed [31:0] n_stick_prod;
    logic [29:0]        n_mag;
    logic [17:0]        n_leg_sum;
    logic signed [17:0] n_leg_diff;
    logic signed [29:0] n_leg_prod;

    logic [29:0]        r_mag;
    logic               r_neg;
    logic signed [29:0] r_leg_prod;
    logic signed [31:0] r_mpos1;
    logic signed [31:0] r_mspd1;

    always_comb begin
        n_stick_prod = 32'(i_stick_forward * $signed({1'b0, i_max_speed}));
        n_mag        = n_stick_prod[31] ? 30'(-n_stick_prod) : n_stick_prod[29:0];
        n_leg_sum    = {1'b0, i_left_leg_length} + {1'b0, i_right_leg_length};
        n_leg_diff   = $signed({1'b0, n_leg_sum[17:1]}) - dsr_pkg::LEG_OFFSET;
        n_leg_prod   = 30'(n_leg_diff * dsr_pkg::LEG_GAIN);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mag      <= n_mag;
            r_neg      <= n_stick_prod[31] ^ i_drive_reversed;
            r_leg_prod <= n_leg_prod;
            r_mpos1    <= i_measured_position;
            r_mspd1    <= i_measured_speed;
        end
    end

    // stage 2: divide by 660 (reciprocal), sign fix, leg step
    logic [57:0]        n_recip;
    logic [20:0]        n_quot;
    logic signed [31:0] n_desired;
    logic signed [29:0] n_leg_rnd;
    logic signed [13:0] n_leg_q;
    logic signed [17:0] n_step;

    logic signed [31:0] r_desired;
    logic [16:0]        r_step;
    logic signed [31:0] r_mpos2;
    logic signed [31:0] r_mspd2;

    always_comb begin
        n_recip   = r_mag[29:2] * dsr_pkg::DIV165_MULT;
        n_quot    = n_recip[57:dsr_pkg::DIV165_SHIFT];
        n_desired = r_neg ? -$signed({11'd0, n_quot}) : $signed({11'd0, n_quot});
        // truncate toward zero
        n_leg_rnd = r_leg_prod[29] ? r_leg_prod + dsr_pkg::Q16_ROUND : r_leg_prod;
        n_leg_q   = n_leg_rnd[29:16];
        n_step    = dsr_pkg::ONE_Q16 - {{4{n_leg_q[13]}}, n_leg_q};
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_desired <= n_desired;
            r_step    <= n_step[16:0];
            r_mpos2   <= r_mpos1;
            r_mspd2   <= r_mspd1;
        end
    end

    assign o_desired           = r_desired;
    assign o_step              = r_step;
    assign o_measured_position = r_mpos2;
    assign o_measured_speed    = r_mspd2;

endmodule

[design/dsr_speed.sv]
// dsr_speed: speed loop stage: command slew and target speed follow/clamp.
// Holds the command and target speed state. Depends on dsr_pkg.
module dsr_speed (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dsr_pkg::t_stage_ctl  i_ctl,
    input  logic signed [31:0]   i_desired,
    input  logic [16:0]          i_step,
    input  logic signed [31:0]   i_measured_position,
    input  logic signed [31:0]   i_measured_speed,
    input  logic [16:0]          i_slew_step,
    input  logic [19:0]          i_speed_window,
    output logic signed [31:0]   o_speed_command,
    output logic signed [31:0]   o_target_speed,
    output logic signed [31:0]   o_speed_raw,
    output logic signed [31:0]   o_measured_position
);

    logic signed [31:0] r_cmd;
    logic signed [31:0] r_tspd;
    logic signed [31:0] r_spd_raw;
    logic signed [31:0] r_mpos;

    logic               n_reset_cmd;
    logic signed [31:0] n_cmd;
    logic signed [31:0] n_spd_raw;
    logic signed [31:0] n_tspd;

    always_comb begin
        // zero desired or strictly opposite signs drop the command to zero
        n_reset_cmd = (i_desired == 32'sd0)
                   || (i_desired > 32'sd0 && r_cmd < 32'sd0)
                   || (i_desired < 32'sd0 && r_cmd > 32'sd0);
        n_cmd       = n_reset_cmd ? 32'sd0 : dsr_pkg::slew(r_cmd, i_desired, i_slew_step);
        n_spd_raw   = dsr_pkg::slew(r_tspd, n_cmd, i_step);
        n_tspd      = dsr_pkg::clamp_around(n_spd_raw, i_measured_speed, i_speed_window);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd  <= '0;
            r_tspd <= '0;
        end else if (i_ctl.adv && i_ctl.vld) begin
            r_cmd  <= n_cmd;
            r_tspd <= n_tspd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_spd_raw <= n_spd_raw;
            r_mpos    <= i_measured_position;
        end
    end

    assign o_speed_command     = r_cmd;
    assign o_target_speed      = r_tspd;
    assign o_speed_raw         = r_spd_raw;
    assign o_measured_position = r_mpos;

endmodule

[design/dsr_position.sv]
// dsr_position: position integration (multiply stage, then accumulate and
// clamp) and the result register. Depends on dsr_pkg.
module dsr_position (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dsr_pkg::t_stage_ctl  i_ctl,
    input  logic signed [31:0]   i_speed_raw,
    input  logic signed [31:0]   i_measured_position,
    input  logic signed [31:0]   i_speed_command,
    input  logic signed [31:0]   i_target_speed,
    input  logic [16:0]          i_tick_period,
    input  logic [16:0]          i_position_window,
    output logic signed [31:0]   o_speed_command,
    output logic signed [31:0]   o_target_speed,
    output logic signed [31:0]   o_target_position
);

    // stage 4: speed * period
    logic signed [49:0] r_prod;
    logic signed [31:0] r_mpos;
    logic signed [31:0] r_cmd4;
    logic signed [31:0] r_tspd4;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod  <= 50'(i_speed_raw * $signed({1'b0, i_tick_period}));
            r_mpos  <= i_measured_position;
            r_cmd4  <= i_speed_command;
            r_tspd4 <= i_target_speed;
        end
    end

    // stage 5: accumulate floor(prod / 2^16), saturate, clamp
    logic signed [33:0] n_inc;
    logic signed [35:0] n_sum;
    logic signed [31:0] n_pos;

    logic signed [31:0] r_pos;
    logic signed [31:0] r_cmd5;
    logic signed [31:0] r_tspd5;

    always_comb begin
        n_inc = r_prod[49:16];
        n_sum = {{4{r_pos[31]}}, r_pos} + {{2{n_inc[33]}}, n_inc};
        n_pos = dsr_pkg::clamp_around(dsr_pkg::sat32(n_sum), r_mpos,
                                      {3'd0, i_position_window});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_ctl.adv && i_ctl.vld) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_cmd5  <= r_cmd4;
            r_tspd5 <= r_tspd4;
        end
    end

    assign o_speed_command   = r_cmd5;
    assign o_target_speed    = r_tspd5;
    assign o_target_position = r_pos;

endmodule

[design/drive_setpoint_ramp.sv]
// drive_setpoint_ramp: per-tick drive setpoint generator (stick scaling, command slew,
// leg-dependent speed ramp, position integration, window clamps); needs dsr_pkg etc.
// Throughput: one word per cycle; the six-stage pipeline stalls as a whole only
// while the result register holds a word that has not been taken.
// Reset (synchronous, active low): pipeline empty, state zero, registers default.
module drive_setpoint_ramp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [dsr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dsr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [10:0]   i_stick_forward,
    input  logic                 i_drive_reversed,
    input  logic [16:0]          i_left_leg_length,
    input  logic [16:0]          i_right_leg_length,
    input  logic signed [31:0]   i_measured_position,
    input  logic signed [31:0]   i_measured_speed,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_speed_command,
    output logic signed [31:0]   o_target_speed,
    output logic signed [31:0]   o_target_position
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [19:0] r_max_speed;
    logic [16:0] r_slew_step;
    logic [16:0] r_pos_window;
    logic [19:0] r_speed_window;
    logic [16:0] r_tick_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed    <= dsr_pkg::RST_MAX_SPEED;
            r_slew_step    <= dsr_pkg::RST_SLEW_STEP;
            r_pos_window   <= dsr_pkg::RST_POS_WINDOW;
            r_speed_window <= dsr_pkg::RST_SPEED_WINDOW;
            r_tick_period  <= dsr_pkg::RST_TICK_PERIOD;
        end else if (i_cfg_we) begin
            unique case (dsr_pkg::t_cfg_idx'(i_cfg_idx))
                dsr_pkg::CFG_MAX_SPEED:    r_max_speed    <= i_cfg_data;
                dsr_pkg::CFG_SLEW_STEP:    r_slew_step    <= i_cfg_data[16:0];
                dsr_pkg::CFG_POS_WINDOW:   r_pos_window   <= i_cfg_data[16:0];
                dsr_pkg::CFG_SPEED_WINDOW: r_speed_window <= i_cfg_data;
                dsr_pkg::CFG_TICK_PERIOD:  r_tick_period  <= i_cfg_data[16:0];
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control
    // Stage 0: input reg     Stage 1-2: front (scale, divide, leg step)
    // Stage 3: speed loop    Stage 4: position product
    // Stage 5: position loop + result register
    // Whole pipeline advances together unless the result is stuck.
    // ---------------------------------------------------------------------
    logic [5:0] r_vld;
    logic       n_adv;

    assign n_adv       = !r_vld[5] || i_out_ready;
    assign o_in_ready  = n_adv;
    assign o_out_valid = r_vld[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_adv) begin
            r_vld <= {r_vld[4:0], i_in_valid};
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0: input register
    // ---------------------------------------------------------------------
    logic signed [10:0] r_stick;
    logic               r_reversed;
    logic [16:0]        r_left;
    logic [16:0]        r_right;
    logic signed [31:0] r_mpos;
    logic signed [31:0] r_mspd;

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_stick    <= i_stick_forward;
            r_reversed <= i_drive_reversed;
            r_left     <= i_left_leg_length;
            r_right    <= i_right_leg_length;
            r_mpos     <= i_measured_position;
            r_mspd     <= i_measured_speed;
        end
    end

    // ---------------------------------------------------------------------
    // Stages 1-2: desired speed and leg-length step (no state)
    // ---------------------------------------------------------------------
    logic signed [31:0] w_desired;
    logic [16:0]        w_step;
    logic signed [31:0] w_mpos2;
    logic signed [31:0] w_mspd2;

    dsr_front u_front (
        .i_clk               (i_clk),
        .i_adv               (n_adv),
        .i_stick_forward     (r_stick),
        .i_drive_reversed    (r_reversed),
        .i_left_leg_length   (r_left),
        .i_right_leg_length  (r_right),
        .i_measured_position (r_mpos),
        .i_measured_speed    (r_mspd),
        .i_max_speed         (r_max_speed),
        .o_desired           (w_desired),
        .o_step              (w_step),
        .o_measured_position (w_mpos2),
        .o_measured_speed    (w_mspd2)
    );

    // ---------------------------------------------------------------------
    // Stage 3: speed loop (command slew, target speed ramp and clamp)
    // ---------------------------------------------------------------------
    dsr_pkg::t_stage_ctl w_speed_ctl;
    logic signed [31:0]  w_cmd3;
    logic signed [31:0]  w_tspd3;
    logic signed [31:0]  w_spd_raw;
    logic signed [31:0]  w_mpos3;

    assign w_speed_ctl.adv = n_adv;
    assign w_speed_ctl.vld = r_vld[2];

    dsr_speed u_speed (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (w_speed_ctl),
        .i_desired           (w_desired),
        .i_step              (w_step),
        .i_measured_position (w_mpos2),
        .i_measured_speed    (w_mspd2),
        .i_slew_step         (r_slew_step),
        .i_speed_window      (r_speed_window),
        .o_speed_command     (w_cmd3),
        .o_target_speed      (w_tspd3),
        .o_speed_raw         (w_spd_raw),
        .o_measured_position (w_mpos3)
    );

    // ---------------------------------------------------------------------
    // Stages 4-5: position integration on the unclamped ramped speed,
    // clamp to the window, result register
    // ---------------------------------------------------------------------
    dsr_pkg::t_stage_ctl w_pos_ctl;

    assign w_pos_ctl.adv = n_adv;
    assign w_pos_ctl.vld = r_vld[4];

    dsr_position u_position (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (w_pos_ctl),
        .i_speed_raw         (w_spd_raw),
        .i_measured_position (w_mpos3),
        .i_speed_command     (w_cmd3),
        .i_target_speed      (w_tspd3),
        .i_tick_period       (r_tick_period),
        .i_position_window   (r_pos_window),
        .o_speed_command     (o_speed_command),
        .o_target_speed      (o_target_speed),
        .o_target_position   (o_target_position)
    );

endmodule

[sim/tb.sv]
// tb: self-checking testbench for drive_setpoint_ramp, driven through its word
// handshakes and config write port. Needs dsr_pkg and the design sources only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int RESET_CYCLES    = 12;
    localparam int PIPE_LATENCY    = 5;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 106;   // ~850 random words in total
    localparam int HOLD_CYCLES     = 60;    // long output back-pressure stretch
    localparam int RUN_LIMIT_NS    = 4_000_000;

    // config index that no register decodes (5..7)
    localparam logic [2:0] CFG_IDX_SPARE = 3'd5;

    // Fixed-point constants of the setpoint math (Q16.16)
    localparam longint STICK_SPAN    = 660;
    localparam longint LEG_BASE_Q16  = 9830;    // 0.15 m
    localparam longint LEG_SLOPE_Q16 = 1966;    // 0.03
    localparam longint Q16_UNIT      = 65536;
    localparam longint S32_MAX       = 64'sd2147483647;
    localparam longint S32_MIN       = -64'sd2147483648;

    // ------------------------------------------------------------------
    // Word types
    // ------------------------------------------------------------------
    typedef struct packed {
        logic signed [10:0] stick;
        logic               reversed;
        logic        [16:0] left_leg;
        logic        [16:0] right_leg;
        logic signed [31:0] meas_pos;
        logic signed [31:0] meas_spd;
    } t_tick_word;

    typedef struct packed {
        logic signed [31:0] speed_command;
        logic signed [31:0] target_speed;
        logic signed [31:0] target_position;
    } t_setpoint;

    typedef struct packed {
        t_tick_word tick;
        logic       typed;     // expected setpoint written in the table
        t_setpoint  want;
    } t_directed_row;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [19:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [10:0] i_stick_forward;
    logic               i_drive_reversed;
    logic [16:0]        i_left_leg_length;
    logic [16:0]        i_right_leg_length;
    logic signed [31:0] i_measured_position;
    logic signed [31:0] i_measured_speed;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_speed_command;
    logic signed [31:0] o_target_speed;
    logic signed [31:0] o_target_position;

    drive_setpoint_ramp DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_stick_forward     (i_stick_forward),
        .i_drive_reversed    (i_drive_reversed),
        .i_left_leg_length   (i_left_leg_length),
        .i_right_leg_length  (i_right_leg_length),
        .i_measured_position (i_measured_position),
        .i_measured_speed    (i_measured_speed),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_speed_command     (o_speed_command),
        .o_target_speed      (o_target_speed),
        .o_target_position   (o_target_position)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_setpoint     expected_setpoints[$];   // oldest first
    t_directed_row directed_rows[$];
    int            fail_count  = 0;
    bit            burst_mode  = 1'b0;      // no idling on either side
    int            hold_asks   = 0;         // bumped to request a long output stall
    int            hold_served = 0;

    // Register mirror, reset defaults
    longint cfg_max_speed = 163840;
    longint cfg_slew_step = 655;
    longint cfg_pos_win   = 6554;
    longint cfg_spd_win   = 98304;
    longint cfg_tick      = 328;

    // Setpoint state mirror, zero after reset
    longint cmd_state = 0;
    longint spd_state = 0;
    longint pos_state = 0;

    // ------------------------------------------------------------------
    // Setpoint predictor
    // ------------------------------------------------------------------
    function automatic longint clip32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // step cur toward goal; land on goal once strictly closer than step
    function automatic longint ramp_toward(input longint cur, input longint goal,
                                           input longint step);
        longint d;
        longint ad;
        d  = goal - cur;
        ad = (d < 0) ? -d : d;
        if (ad < step) return goal;
        return (d > 0) ? cur + step : cur - step;
    endfunction

    function automatic longint window_clamp(input longint v, input longint center,
                                            input longint win);
        if (v - center > win) return center + win;
        if (v - center < -win) return center - win;
        return v;
    endfunction

    // One control tick: updates the state mirror, returns the setpoint word
    function automatic t_setpoint predict_setpoint(input t_tick_word w);
        longint    stick;
        longint    desired;
        longint    cmd;
        longint    avg_leg;
        longint    leg_step;
        longint    spd;
        longint    pos;
        t_setpoint r;
        stick   = longint'($signed(w.stick));
        desired = (stick * cfg_max_speed) / STICK_SPAN;   // truncates toward zero
        if (w.reversed) desired = -desired;

        // zero demand or a sign flip drops the command at once
        cmd = cmd_state;
        if (desired == 0 || (desired > 0 && cmd < 0) || (desired < 0 && cmd > 0))
            cmd = 0;
        else
            cmd = ramp_toward(cmd, desired, cfg_slew_step);
        cmd_state = clip32(cmd);

        // longer legs give a smaller speed step
        avg_leg  = (longint'(w.left_leg) + longint'(w.right_leg)) / 2;
        leg_step = Q16_UNIT - ((avg_leg - LEG_BASE_Q16) * LEG_SLOPE_Q16) / Q16_UNIT;

        spd = clip32(ramp_toward(spd_state, cmd_state, leg_step));
        // >>> on a signed longint floors, as the integration wants
        pos = clip32(pos_state + ((spd * cfg_tick) >>> 16));
        pos_state = clip32(window_clamp(pos, longint'($signed(w.meas_pos)), cfg_pos_win));
        spd_state = clip32(window_clamp(spd, longint'($signed(w.meas_spd)), cfg_spd_win));

        r.speed_command   = cmd_state[31:0];
        r.target_speed    = spd_state[31:0];
        r.target_position = pos_state[31:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // meas_mode 0: near the tracked state, 1: any value, 2: near the 32-bit limits
    function automatic t_tick_word make_tick_word(input logic signed [10:0] stick,
                                                  input logic rev, input int meas_mode);
        t_tick_word w;
        longint     span;
        int         r;
        w.stick    = stick;
        w.reversed = rev;
        r = $urandom_range(0, 19);
        if (r < 17) begin
            w.left_leg  = 17'($urandom_range(0, 65536));
            w.right_leg = 17'($urandom_range(0, 65536));
        end else if (r < 19) begin
            w.left_leg  = 17'($urandom);
            w.right_leg = 17'($urandom);
        end else begin
            w.left_leg  = $urandom_range(0, 1) ? 17'h1FFFF : 17'd0;
            w.right_leg = $urandom_range(0, 1) ? 17'h1FFFF : 17'd65536;
        end
        case (meas_mode)
            0: begin
                span = cfg_pos_win + 2048;
                w.meas_pos = 32'(clip32(pos_state
                                 + longint'($urandom_range(0, int'(2 * span))) - span));
                span = cfg_spd_win + 8192;
                w.meas_spd = 32'(clip32(spd_state
                                 + longint'($urandom_range(0, int'(2 * span))) - span));
            end
            1: begin
                w.meas_pos = $urandom;
                w.meas_spd = $urandom;
            end
            default: begin
                span = cfg_pos_win + 4096;
                w.meas_pos = $urandom_range(0, 1)
                    ? 32'(S32_MAX - longint'($urandom_range(0, int'(span))))
                    : 32'(S32_MIN + longint'($urandom_range(0, int'(span))));
                span = cfg_spd_win + 4096;
                w.meas_spd = $urandom_range(0, 1)
                    ? 32'(S32_MAX - longint'($urandom_range(0, int'(span))))
                    : 32'(S32_MIN + longint'($urandom_range(0, int'(span))));
            end
        endcase
        return w;
    endfunction

    task automatic add_row(input logic signed [10:0] stick, input logic rev,
                           input logic [16:0] left_leg, input logic [16:0] right_leg,
                           input logic signed [31:0] meas_pos,
                           input logic signed [31:0] meas_spd,
                           input logic typed, input logic signed [31:0] want_cmd,
                           input logic signed [31:0] want_spd,
                           input logic signed [31:0] want_pos);
        t_directed_row row;
        row.tick.stick     = stick;
        row.tick.reversed  = rev;
        row.tick.left_leg  = left_leg;
        row.tick.right_leg = right_leg;
        row.tick.meas_pos  = meas_pos;
        row.tick.meas_spd  = meas_spd;
        row.typed          = typed;
        row.want.speed_command   = want_cmd;
        row.want.target_speed    = want_spd;
        row.want.target_position = want_pos;
        directed_rows.push_back(row);
    endtask

    // Called at a falling edge, returns at a falling edge. Valid is left high
    // after acceptance so a back-to-back word can follow without a gap.
    task automatic offer_word(input t_tick_word w, input logic typed,
                              input t_setpoint want);
        int        gap;
        t_setpoint pred;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_stick_forward     = w.stick;
        i_drive_reversed    = w.reversed;
        i_left_leg_length   = w.left_leg;
        i_right_leg_length  = w.right_leg;
        i_measured_position = w.meas_pos;
        i_measured_speed    = w.meas_spd;
        i_in_valid          = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        // predictor runs in acceptance order
        pred = predict_setpoint(w);
        expected_setpoints.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every pending setpoint word
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (expected_setpoints.size() != 0) @(negedge i_clk);
    endtask

    // Config write at a falling edge; the mirror follows the register widths
    task automatic cfg_write(input logic [2:0] idx, input logic [19:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            dsr_pkg::CFG_MAX_SPEED:    cfg_max_speed = longint'(data);
            dsr_pkg::CFG_SLEW_STEP:    cfg_slew_step = longint'(data[16:0]);
            dsr_pkg::CFG_POS_WINDOW:   cfg_pos_win   = longint'(data[16:0]);
            dsr_pkg::CFG_SPEED_WINDOW: cfg_spd_win   = longint'(data);
            dsr_pkg::CFG_TICK_PERIOD:  cfg_tick      = longint'(data[16:0]);
            default: ;   // unmapped index: ignored
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_config(input logic [19:0] max_speed, input logic [19:0] slew,
                               input logic [19:0] pos_win, input logic [19:0] spd_win,
                               input logic [19:0] tick);
        cfg_write(dsr_pkg::CFG_MAX_SPEED, max_speed);
        cfg_write(dsr_pkg::CFG_SLEW_STEP, slew);
        cfg_write(dsr_pkg::CFG_POS_WINDOW, pos_win);
        cfg_write(dsr_pkg::CFG_SPEED_WINDOW, spd_win);
        cfg_write(dsr_pkg::CFG_TICK_PERIOD, tick);
        // a write to an unmapped index must leave everything alone
        cfg_write(CFG_IDX_SPARE + 3'($urandom_range(0, 2)), 20'($urandom));
    endtask

    function automatic logic [19:0] rand_reg(input int hi);
        // mostly within the stated range, now and then any bit pattern
        if ($urandom_range(0, 7) == 0) return 20'($urandom);
        return 20'($urandom_range(0, hi));
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, plus the long hold when asked
    // ------------------------------------------------------------------
    initial begin : result_side
        t_setpoint want;
        int        stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                stall_left  = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                stall_left  = burst_mode ? 0 : pick_gap();
            end
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (expected_setpoints.size() == 0) begin
                    $display("%0t: setpoint word with none expected, cmd %0d spd %0d pos %0d",
                             $time, o_speed_command, o_target_speed, o_target_position);
                    fail_count++;
                end else begin
                    want = expected_setpoints.pop_front();
                    check_field("speed_command", want.speed_command, o_speed_command);
                    check_field("target_speed", want.target_speed, o_target_speed);
                    check_field("target_position", want.target_position,
                                o_target_position);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic signed [10:0] stick;
        logic               rev;
        int                 meas_mode;
        int                 r;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = dsr_pkg::CFG_MAX_SPEED;
        i_cfg_data          = 20'd0;
        i_in_valid          = 1'b0;
        i_stick_forward     = 11'sd0;
        i_drive_reversed    = 1'b0;
        i_left_leg_length   = 17'd0;
        i_right_leg_length  = 17'd0;
        i_measured_position = 32'sd0;
        i_measured_speed    = 32'sd0;
        stick = 11'sd0;
        rev   = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table, reset register values.
        //       stick    rev  left     right    meas_pos       meas_spd       typed?
        // Fresh state, no stick: everything stays at zero.
        add_row(11'sd0,    0, 17'd0,      17'd0,      32'sd0,        32'sd0,
                1, 32'sd0, 32'sd0, 32'sd0);
        // Measured values at the 32-bit limits: both outputs pinned to the
        // window edge next to them (max - 6554, min + 98304).
        add_row(11'sd0,    0, 17'h1FFFF,  17'h1FFFF,  32'sh7FFF_FFFF, 32'sh8000_0000,
                1, 32'sd0, 32'sh8001_8000, 32'sh7FFF_E665);
        add_row(11'sd0,    0, 17'd0,      17'd0,      32'sd0,        32'sd0,   0, 0, 0, 0);
        // full stick ramp
        add_row(11'sd660,  0, 17'd65536,  17'd65536,  32'sd0,        32'sd0,   0, 0, 0, 0);
        add_row(11'sd660,  0, 17'd65536,  17'd65536,  32'sd0,        32'sd0,   0, 0, 0, 0);
        add_row(11'sd660,  0, 17'd65536,  17'd65536,  32'sd100,      32'sd500, 0, 0, 0, 0);
        add_row(11'sd660,  0, 17'd65536,  17'd65536,  32'sd200,      32'sd900, 0, 0, 0, 0);
        // sign flip drops the command, then ramps the other way
        add_row(-11'sd660, 0, 17'd65536,  17'd65536,  32'sd0,        32'sd0,   0, 0, 0, 0);
        add_row(-11'sd660, 0, 17'd65536,  17'd65536,  32'sd0,        32'sd0,   0, 0, 0, 0);
        // reversed drive inverts the demand
        add_row(11'sd660,  1, 17'd65536,  17'd65536,  32'sd0,        32'sd0,   0, 0, 0, 0);
        // tiny demand: flips sign first, then lands on it in one step
        add_row(11'sd1,    0, 17'd32768,  17'd32768,  32'sd0,        32'sd0,   0, 0, 0, 0);
        add_row(11'sd1,    0, 17'd32768,  17'd32768,  32'sd0,        32'sd0,   0, 0, 0, 0);
        // stick past full scale is used as is
        add_row(11'sd1023, 0, 17'd32768,  17'd32768,  32'sd0,        32'sd0,   0, 0, 0, 0);
        add_row(-11'sd1024, 0, 17'd32768, 17'd32768,  32'sd0,        32'sd0,   0, 0, 0, 0);
        add_row(-11'sd1024, 1, 17'd32768, 17'd32768,  32'sd0,        32'sd0,   0, 0, 0, 0);
        // leg lengths: at the 0.15 m pivot, odd sum, above range
        add_row(11'sd660,  0, 17'd9830,   17'd9830,   32'sd0,        32'sd0,   0, 0, 0, 0);
        add_row(11'sd660,  0, 17'd0,      17'h1FFFF,  32'sd0,        32'sd0,   0, 0, 0, 0);
        add_row(11'sd660,  0, 17'h1FFFF,  17'h1FFFE,  32'sd0,        32'sd0,   0, 0, 0, 0);
        add_row(11'sd660,  0, 17'd65536,  17'd65536,  32'sh8000_0000, 32'sh7FFF_FFFF,
                0, 0, 0, 0);
        add_row(11'sd0,    0, 17'd65536,  17'd65536,  32'sd0,        32'sd0,   0, 0, 0, 0);

        foreach (directed_rows[i])
            offer_word(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: ;    // keep the reset values
                1: load_config(20'hFFFFF, 20'h1FFFF, 20'h1FFFF, 20'hFFFFF, 20'h1FFFF);
                2: load_config(20'd0, 20'd0, 20'd0, 20'd0, 20'd0);   // tick 0: no integration
                3: load_config(20'd655360, 20'd65536, 20'd65536, 20'd655360, 20'd1);
                default: load_config(rand_reg(655360), rand_reg(65536), rand_reg(65536),
                                     rand_reg(655360), 20'($urandom_range(1, 65536)));
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // phase 3: stall results for a long stretch while words keep coming
                if (ph == 3 && k == 20) hold_asks++;
                burst_mode = (ph == 5) || (ph == 3 && k >= 20 && k < 50);

                // hold the stick for a while so the ramps get somewhere
                if (k == 0 || $urandom_range(0, 11) == 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: stick = 11'(int'($urandom_range(0, 1320)) - 660);
                        4:          stick = 11'sd0;
                        5:          stick = 11'sd660;
                        6:          stick = -11'sd660;
                        7:          stick = 11'($urandom_range(0, 2047));
                        default:    stick = 11'(int'($urandom_range(0, 60)) - 30);
                    endcase
                end
                if ($urandom_range(0, 19) == 0) rev = ~rev;

                r = $urandom_range(0, 99);
                if (ph == 1)
                    meas_mode = (r < 60) ? 0 : (r < 70) ? 1 : 2;
                else
                    meas_mode = (r < 80) ? 0 : (r < 92) ? 1 : 2;

                offer_word(make_tick_word(stick, rev, meas_mode), 1'b0, '0);
            end
            burst_mode = 1'b0;
        end

        drain_results();
        repeat (4 * PIPE_LATENCY) @(negedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
